[hw/rtl/wmmg_pkg.sv]
// Shared types, constants and small sort helpers for the 3x3 window filter.
package wmmg_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int DimW      = 11;
  localparam int PixW      = 8;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);
  localparam logic [DimW-1:0] DimMin      = DimW'(3);

  // register index, taken from paddr[2]
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // ceil(2^16 / 9): exact floor division of sums up to 2295
  localparam logic [12:0] RecipNine = 13'd7282;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            border;
    logic            last;
  } pos_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

[hw/rtl/wmmg_col_cell.sv]
// One window column cell: holds three vertically stacked pixels, shifts left.
module wmmg_col_cell (
  input  logic               clk,
  input  logic               en,
  input  wmmg_pkg::col_t     d,
  output wmmg_pkg::col_t     q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

[hw/rtl/wmmg_sort_cell.sv]
// Registered three-input sorter cell used on each window row.
module wmmg_sort_cell (
  input  logic             clk,
  input  logic             en,
  input  wmmg_pkg::pix_t   a,
  input  wmmg_pkg::pix_t   b,
  input  wmmg_pkg::pix_t   c,
  output wmmg_pkg::pix_t   lo,
  output wmmg_pkg::pix_t   md,
  output wmmg_pkg::pix_t   hi
);

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= wmmg_pkg::min3(a, b, c);
      md <= wmmg_pkg::med3(a, b, c);
      hi <= wmmg_pkg::max3(a, b, c);
    end
  end

endmodule

[hw/rtl/window3x3_median_mean_gauss.sv]
// Top level: 3x3 median, mean and Gaussian filter over a raster pixel stream.
// Throughput: one beat per cycle, pixel or flush, with no stall downstream.
// A released result passes the stage 1 to stage 4 registers and the output register;
// results lag the pixel stream by image_width+1 beats.
// Reset (rst, synchronous): counters cleared, size back to 640 x 480, pipe empty.
// Line stores are not cleared; unwritten entries only feed border outputs.
module window3x3_median_mean_gauss (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [7:0]                    pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    median_value,
  output logic [7:0]                    mean_value,
  output logic [7:0]                    gauss_value,
  output logic [9:0]                    out_row,
  output logic [9:0]                    out_column,
  output logic                          frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int ColW = wmmg_pkg::ColW;
  localparam int RowW = wmmg_pkg::RowW;
  localparam int DimW = wmmg_pkg::DimW;

  // ---------------- configuration ----------------
  logic [DimW-1:0] image_width, image_height;
  logic            cfg_wr;
  logic [DimW-1:0] cfg_val;
  logic [DimW-1:0] cfg_max;
  logic [DimW-1:0] cfg_clamped;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_val = pwdata[DimW-1:0];
  assign cfg_max = (paddr[2] == wmmg_pkg::RegHeight) ? DimW'(wmmg_pkg::MaxHeight)
                                                    : DimW'(wmmg_pkg::MaxWidth);

  always_comb begin
    cfg_clamped = cfg_val;
    if (cfg_val < wmmg_pkg::DimMin) begin
      cfg_clamped = wmmg_pkg::DimMin;
    end else if (cfg_val > cfg_max) begin
      cfg_clamped = cfg_max;
    end
  end

  always_comb begin
    case (paddr[2])
      wmmg_pkg::RegWidth:  prdata = {{(32-DimW){1'b0}}, image_width};
      wmmg_pkg::RegHeight: prdata = {{(32-DimW){1'b0}}, image_height};
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline handshake ----------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_adv, s2_adv, s3_adv, s4_adv;
  logic in_acc;

  assign s4_adv   = !out_valid || !out_stall;
  assign s3_adv   = !s4_valid || s4_adv;
  assign s2_adv   = !s3_valid || s3_adv;
  assign s1_adv   = !s2_valid || s2_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------- position tracking ----------------
  logic [ColW-1:0] in_col, out_col;
  logic [RowW-1:0] in_row, out_row_q;
  logic [DimW-1:0] pend;
  logic            is_pix, go, flush_go, emit;
  logic            in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic [ColW-1:0] flush_col, rd_addr;
  wmmg_pkg::pos_t  pos_now;

  assign is_pix       = (kind == 1'b0);
  assign go           = ({1'b0, pend} >= ({1'b0, image_width} + 12'd1));
  assign flush_go     = (in_col == '0) && (in_row == '0) && (pend != '0);
  assign emit         = is_pix ? go : flush_go;
  assign in_col_wrap  = ({1'b0, in_col} + DimW'(1)) == image_width;
  assign in_row_wrap  = ({1'b0, in_row} + DimW'(1)) == image_height;
  assign out_col_wrap = ({1'b0, out_col} + DimW'(1)) == image_width;
  assign out_row_wrap = ({1'b0, out_row_q} + DimW'(1)) == image_height;
  assign flush_col    = out_col_wrap ? '0 : out_col + ColW'(1);
  assign rd_addr      = is_pix ? in_col : flush_col;

  assign pos_now.row    = out_row_q;
  assign pos_now.col    = out_col;
  assign pos_now.border = (out_row_q == '0) || out_row_wrap || (out_col == '0) || out_col_wrap;
  assign pos_now.last   = out_row_wrap && out_col_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wmmg_pkg::WidthReset;
      image_height <= wmmg_pkg::HeightReset;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row_q    <= '0;
      pend         <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        wmmg_pkg::RegWidth:  image_width  <= cfg_clamped;
        wmmg_pkg::RegHeight: image_height <= cfg_clamped;
        default:             image_width  <= image_width;
      endcase
      in_col    <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row_q <= '0;
      pend      <= '0;
    end else if (in_acc) begin
      if (is_pix) begin
        in_col <= in_col_wrap ? '0 : in_col + ColW'(1);
        if (in_col_wrap) begin
          in_row <= in_row_wrap ? '0 : in_row + RowW'(1);
        end
        if (!go) begin
          pend <= pend + DimW'(1);
        end
      end else if (flush_go) begin
        pend <= pend - DimW'(1);
      end
      if (emit) begin
        out_col <= out_col_wrap ? '0 : out_col + ColW'(1);
        if (out_col_wrap) begin
          out_row_q <= out_row_wrap ? '0 : out_row_q + RowW'(1);
        end
      end
    end
  end

  // ---------------- stage 1: line store read ----------------
  logic [15:0]     line_mem [wmmg_pkg::MaxWidth];
  logic [15:0]     rd_data, s1_fwd;
  logic            s1_hit, s1_emit, s1_pixel;
  wmmg_pkg::pix_t  s1_pix, s1_up, s1_lo;
  logic [ColW-1:0] s1_addr;
  wmmg_pkg::pos_t  s1_pos;
  logic            s1_wr;

  assign s1_up = s1_hit ? s1_fwd[15:8] : rd_data[15:8];
  assign s1_lo = s1_hit ? s1_fwd[7:0]  : rd_data[7:0];
  assign s1_wr = s1_valid && s1_adv && s1_pixel;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= line_mem[rd_addr];
    end
    if (s1_wr) begin
      line_mem[s1_addr] <= {s1_lo, s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_adv) begin
      s1_valid <= in_acc && (is_pix || flush_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit  <= emit;
      s1_pixel <= is_pix;
      s1_pix   <= pixel;
      s1_addr  <= rd_addr;
      s1_pos   <= pos_now;
      // the store write in flight at this edge is not seen by the read: forward it
      s1_hit   <= s1_wr && (s1_addr == rd_addr);
      s1_fwd   <= {s1_lo, s1_pix};
    end
  end

  // ---------------- stage 2: window shift chain ----------------
  wmmg_pkg::col_t new_col, w0, w1, w2;
  logic           shift;
  wmmg_pkg::pos_t s2_pos;

  assign shift       = s1_valid && s1_adv;
  assign new_col.top = s1_up;
  assign new_col.mid = s1_lo;
  assign new_col.bot = s1_pixel ? s1_pix : '0;

  wmmg_col_cell u_cell2 (.clk(clk), .en(shift), .d(new_col), .q(w2));
  wmmg_col_cell u_cell1 (.clk(clk), .en(shift), .d(w2),      .q(w1));
  wmmg_col_cell u_cell0 (.clk(clk), .en(shift), .d(w1),      .q(w0));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || s2_adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      s2_pos <= s1_pos;
    end
  end

  // ---------------- stage 3: row sort, sums ----------------
  wmmg_pkg::pix_t lo0, md0, hi0, lo1, md1, hi1, lo2, md2, hi2;
  logic [11:0]    sum_c, gsum_c, s3_sum, s3_gsum;
  wmmg_pkg::pix_t s3_ctr;
  wmmg_pkg::pos_t s3_pos;
  logic           s3_ld;

  assign s3_ld = !s3_valid || s3_adv;

  wmmg_sort_cell u_sort0 (.clk(clk), .en(s3_ld), .a(w0.top), .b(w1.top), .c(w2.top),
                          .lo(lo0), .md(md0), .hi(hi0));
  wmmg_sort_cell u_sort1 (.clk(clk), .en(s3_ld), .a(w0.mid), .b(w1.mid), .c(w2.mid),
                          .lo(lo1), .md(md1), .hi(hi1));
  wmmg_sort_cell u_sort2 (.clk(clk), .en(s3_ld), .a(w0.bot), .b(w1.bot), .c(w2.bot),
                          .lo(lo2), .md(md2), .hi(hi2));

  assign sum_c = 12'(w0.top) + 12'(w1.top) + 12'(w2.top)
               + 12'(w0.mid) + 12'(w1.mid) + 12'(w2.mid)
               + 12'(w0.bot) + 12'(w1.bot) + 12'(w2.bot);
  assign gsum_c = 12'(w0.top) + 12'(w2.top) + 12'(w0.bot) + 12'(w2.bot)
                + {3'b0, w1.top, 1'b0} + {3'b0, w1.bot, 1'b0}
                + {3'b0, w0.mid, 1'b0} + {3'b0, w2.mid, 1'b0}
                + {2'b0, w1.mid, 2'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ld) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_sum  <= sum_c;
      s3_gsum <= gsum_c;
      s3_ctr  <= w1.mid;
      s3_pos  <= s2_pos;
    end
  end

  // ---------------- stage 4: partial median, reciprocal multiply ----------------
  wmmg_pkg::pix_t s4_maxlo, s4_medmd, s4_minhi, s4_gauss, s4_ctr;
  logic [24:0]    s4_prod;
  wmmg_pkg::pos_t s4_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s3_adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s4_maxlo <= wmmg_pkg::max3(lo0, lo1, lo2);
      s4_medmd <= wmmg_pkg::med3(md0, md1, md2);
      s4_minhi <= wmmg_pkg::min3(hi0, hi1, hi2);
      s4_prod  <= s3_sum * wmmg_pkg::RecipNine;
      s4_gauss <= s3_gsum[11:4];
      s4_ctr   <= s3_ctr;
      s4_pos   <= s3_pos;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_adv) begin
      if (s4_pos.border) begin
        median_value <= s4_ctr;
        mean_value   <= s4_ctr;
        gauss_value  <= s4_ctr;
      end else begin
        median_value <= wmmg_pkg::med3(s4_maxlo, s4_medmd, s4_minhi);
        mean_value   <= s4_prod[23:16];
        gauss_value  <= s4_gauss;
      end
      out_row    <= s4_pos.row;
      out_column <= s4_pos.col;
      frame_end  <= s4_pos.last;
    end
  end

endmodule

[hw/rtl/wmmg_checker.sv]
// Port-level checks for the 3x3 window filter, bound to the top level.
module wmmg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  median_value,
  input logic [7:0]  mean_value,
  input logic [7:0]  gauss_value,
  input logic [9:0]  out_row,
  input logic [9:0]  out_column,
  input logic        frame_end
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median_value) && $stable(out_column))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // left and top edges pass the center pixel through
  a_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_column == 10'd0 || out_row == 10'd0) |->
      median_value == mean_value && mean_value == gauss_value)
    else $error("border pixel not passed through");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_row != 10'd0 && out_column != 10'd0)
    else $error("frame end on first row or column");

endmodule

bind window3x3_median_mean_gauss wmmg_checker u_wmmg_checker (.*);
